// ----- sv/swmm_pkg.sv -----
package swmm_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic step;
        logic visible;
        logic hit;
    } scan_ctl_t;

    localparam int unsigned INDEX_BITS = 7;
    localparam int unsigned COUNT_OUT_BITS = 8;
    localparam int unsigned SLOT_OUT_BITS = 7;

endpackage

// ----- sv/swmm_cell.sv -----
module swmm_cell #(
    parameter int unsigned DW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  logic [DW-1:0] din,
    output logic [DW-1:0] dout
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    always_comb
    begin
        data_next = shift_en ? din : data_reg;
    end

    // window starts full of zeros, so the cell contents are cleared too
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// ----- sv/swmm_scan.sv -----
module swmm_scan #(
    parameter int unsigned DW = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swmm_pkg::scan_ctl_t ctl,
    input  logic [DW-1:0]       value,
    output logic [DW-1:0]       min_value,
    output logic [DW-1:0]       max_value,
    output logic [DW-1:0]       read_data
);

    logic [DW-1:0] min_reg;
    logic [DW-1:0] min_next;
    logic [DW-1:0] max_reg;
    logic [DW-1:0] max_next;
    logic [DW-1:0] rd_reg;
    logic [DW-1:0] rd_next;
    logic          seen_reg;
    logic          seen_next;

    always_comb
    begin
        min_next  = min_reg;
        max_next  = max_reg;
        rd_next   = rd_reg;
        seen_next = seen_reg;
        if (ctl.start)
        begin
            seen_next = 1'b0;
            rd_next   = '0;
        end
        else if (ctl.step)
        begin
            if (ctl.visible)
            begin
                seen_next = 1'b1;
                if (!seen_reg || value < min_reg)
                begin
                    min_next = value;
                end
                if (!seen_reg || value > max_reg)
                begin
                    max_next = value;
                end
            end
            if (ctl.hit)
            begin
                rd_next = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        rd_reg  <= rd_next;
    end

    // empty window reports zero
    assign min_value = seen_reg ? min_reg : '0;
    assign max_value = seen_reg ? max_reg : '0;
    assign read_data = rd_reg;

endmodule

// ----- sv/sliding_window_min_max_buffer.sv -----
// an accepted input transaction passes through ST_SCAN and then ST_DONE before out_valid is raised
// a new transaction is taken only in ST_IDLE, after one full rotation of the cell chain
//   past the single compare unit at its head
// a new input is taken while the previous result still waits in the output register
// reset (rst_n, asynchronous, active low): all cells zero, count = WINDOW, idle
module sliding_window_min_max_buffer #(
    parameter int unsigned WINDOW      = 128,
    parameter int unsigned SAMPLE_BITS = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic [swmm_pkg::INDEX_BITS-1:0]     index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SAMPLE_BITS-1:0]              read_value,
    output logic [SAMPLE_BITS-1:0]              window_min,
    output logic [SAMPLE_BITS-1:0]              window_max,
    output logic [swmm_pkg::COUNT_OUT_BITS-1:0] sample_count,
    output logic [swmm_pkg::SLOT_OUT_BITS-1:0]  next_slot,
    output logic                                window_empty,
    output logic                                index_error
);

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned POS_W = $clog2(WINDOW);
    // wide enough for position + count and WINDOW + index
    localparam int unsigned SW = ((CNT_W > swmm_pkg::INDEX_BITS) ? CNT_W
                                  : swmm_pkg::INDEX_BITS) + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // the chain holds samples right-aligned by age: the newest sits in the
    // last cell, the sample at index a (counted from the oldest) sits in cell WINDOW - count + a
    logic [SAMPLE_BITS-1:0] cell_q [WINDOW];
    logic [SAMPLE_BITS-1:0] tail_din;
    logic                   chain_shift;

    state_t                      state_reg;
    state_t                      state_next;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    swmm_pkg::cmd_t              cmd_reg;
    swmm_pkg::cmd_t              cmd_next;
    logic [swmm_pkg::INDEX_BITS-1:0] idx_reg;
    logic [swmm_pkg::INDEX_BITS-1:0] idx_next;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [SAMPLE_BITS-1:0]              rd_out_reg;
    logic [SAMPLE_BITS-1:0]              rd_out_next;
    logic [SAMPLE_BITS-1:0]              min_out_reg;
    logic [SAMPLE_BITS-1:0]              min_out_next;
    logic [SAMPLE_BITS-1:0]              max_out_reg;
    logic [SAMPLE_BITS-1:0]              max_out_next;
    logic [swmm_pkg::COUNT_OUT_BITS-1:0] count_out_reg;
    logic [swmm_pkg::COUNT_OUT_BITS-1:0] count_out_next;
    logic [swmm_pkg::SLOT_OUT_BITS-1:0]  slot_out_reg;
    logic [swmm_pkg::SLOT_OUT_BITS-1:0]  slot_out_next;
    logic                                empty_out_reg;
    logic                                empty_out_next;
    logic                                err_out_reg;
    logic                                err_out_next;

    logic                in_fire;
    logic                put_fire;
    logic                scanning;
    logic                full;
    logic                read_ok;
    logic [SW-1:0]       pos_plus_count;
    swmm_pkg::scan_ctl_t scan_ctl;
    logic [SAMPLE_BITS-1:0] scan_min;
    logic [SAMPLE_BITS-1:0] scan_max;
    logic [SAMPLE_BITS-1:0] scan_rd;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign put_fire = in_fire && (swmm_pkg::cmd_t'(command) == swmm_pkg::CMD_PUT);
    assign scanning = (state_reg == ST_SCAN);
    assign full     = (count_reg == CNT_W'(WINDOW));

    // a put shifts the new sample in at the tail and drops the head cell, which holds a window sample only when full;
    // during the scan the chain rotates so each cell passes the head once
    assign chain_shift = put_fire || scanning;
    assign tail_din    = scanning ? cell_q[0] : sample;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            logic [SAMPLE_BITS-1:0] cell_din;
            if (gi == WINDOW - 1)
            begin : g_tail
                assign cell_din = tail_din;
            end
            else
            begin : g_body
                assign cell_din = cell_q[gi+1];
            end
            swmm_cell #(
                .DW (SAMPLE_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (chain_shift),
                .din      (cell_din),
                .dout     (cell_q[gi])
            );
        end
    endgenerate

    // head cell at scan step p holds original cell p; it is part of the
    // window when p + count >= WINDOW, and the read target when it equals
    // WINDOW + index
    assign pos_plus_count = SW'(pos_reg) + SW'(count_reg);
    assign read_ok = (cmd_reg == swmm_pkg::CMD_READ) && (SW'(idx_reg) < SW'(count_reg));

    always_comb
    begin
        scan_ctl.start   = in_fire;
        scan_ctl.step    = scanning;
        scan_ctl.visible = (pos_plus_count >= SW'(WINDOW));
        scan_ctl.hit     = read_ok && (pos_plus_count == (SW'(WINDOW) + SW'(idx_reg)));
    end

    swmm_scan #(
        .DW (SAMPLE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .value     (cell_q[0]),
        .min_value (scan_min),
        .max_value (scan_max),
        .read_data (scan_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        rd_out_next    = rd_out_reg;
        min_out_next   = min_out_reg;
        max_out_next   = max_out_reg;
        count_out_next = count_out_reg;
        slot_out_next  = slot_out_reg;
        empty_out_next = empty_out_reg;
        err_out_next   = err_out_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = swmm_pkg::cmd_t'(command);
                    idx_next   = index;
                    pos_next   = '0;
                    state_next = ST_SCAN;
                    case (swmm_pkg::cmd_t'(command))
                        swmm_pkg::CMD_PUT:
                        begin
                            if (!full)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        swmm_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_W'(WINDOW - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    rd_out_next    = scan_rd;
                    min_out_next   = scan_min;
                    max_out_next   = scan_max;
                    count_out_next = swmm_pkg::COUNT_OUT_BITS'(count_reg);
                    slot_out_next  = full ? '0 : swmm_pkg::SLOT_OUT_BITS'(count_reg);
                    empty_out_next = (count_reg == '0);
                    err_out_next   = (cmd_reg == swmm_pkg::CMD_READ) && !read_ok;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= CNT_W'(WINDOW);
            cmd_reg       <= swmm_pkg::CMD_NONE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, qualified by out_valid
    always_ff @(posedge clk)
    begin
        rd_out_reg    <= rd_out_next;
        min_out_reg   <= min_out_next;
        max_out_reg   <= max_out_next;
        count_out_reg <= count_out_next;
        slot_out_reg  <= slot_out_next;
        empty_out_reg <= empty_out_next;
        err_out_reg   <= err_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = rd_out_reg;
    assign window_min   = min_out_reg;
    assign window_max   = max_out_reg;
    assign sample_count = count_out_reg;
    assign next_slot    = slot_out_reg;
    assign window_empty = empty_out_reg;
    assign index_error  = err_out_reg;

endmodule
